// ===== rtl/lkv_pkg.sv =====
// Package for the LRU key-value cache: sizes, command codes, request and response words.
// No dependencies; imported by lkv_store, lru_key_value_cache_unit and both testbench files.
package lkv_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AGE_W     = IDX_W;
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int CAP_W     = 5;
  localparam int DATA_W    = 32;
  localparam int CAP_RESET = 16;

  localparam logic signed [DATA_W-1:0] MISS_VALUE = -1;
  localparam logic signed [DATA_W-1:0] PUT_VALUE  = '0;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
  } rsp_t;

endpackage

// ===== rtl/lkv_store.sv =====
// Entry storage and LRU bookkeeping: parallel key match, age update, insert/evict.
// Depends on lkv_pkg. The response is combinational from the current state.
module lkv_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  lkv_pkg::req_t               req,
  output lkv_pkg::rsp_t               rsp,
  input  logic                        cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0]   cfg_data
);
  import lkv_pkg::*;

  logic [DATA_W-1:0]  keys_r     [ENTRIES];
  logic [DATA_W-1:0]  values_r   [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [AGE_W-1:0]   age_r      [ENTRIES];
  logic [CNT_W-1:0]   count_r;
  logic [CAP_W-1:0]   capacity_r;

  logic [DATA_W-1:0]  keys_nxt   [ENTRIES];
  logic [DATA_W-1:0]  values_nxt [ENTRIES];
  logic [ENTRIES-1:0] valid_nxt;
  logic [AGE_W-1:0]   age_nxt    [ENTRIES];
  logic [CNT_W-1:0]   count_nxt;

  logic [ENTRIES-1:0] match;
  logic [IDX_W-1:0]   found_idx;
  logic [IDX_W-1:0]   free_idx;
  logic [IDX_W-1:0]   victim_idx;
  logic               victim_ok;
  logic               hit;
  logic [AGE_W-1:0]   found_age;
  logic [CNT_W-1:0]   cap;

  // effective capacity saturates at the entry count
  always_comb begin
    if (32'(capacity_r) > 32'(ENTRIES)) begin
      cap = CNT_W'(ENTRIES);
    end else begin
      cap = CNT_W'(capacity_r);
    end
  end

  always_comb begin
    found_idx  = '0;
    free_idx   = '0;
    victim_idx = '0;
    victim_ok  = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (keys_r[i] == req.key);
    end
    // lowest index wins
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        found_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
      if (valid_r[i] && (CNT_W'(age_r[i]) == count_r - CNT_W'(1))) begin
        victim_idx = IDX_W'(i);
        victim_ok  = 1'b1;
      end
    end
    hit       = |match;
    found_age = age_r[found_idx];
  end

  always_comb begin
    rsp.hit = hit;
    if (req.cmd == CMD_PUT) begin
      rsp.read_value = PUT_VALUE;
    end else if (hit) begin
      rsp.read_value = values_r[found_idx];
    end else begin
      rsp.read_value = MISS_VALUE;
    end
  end

  always_comb begin
    keys_nxt   = keys_r;
    values_nxt = values_r;
    valid_nxt  = valid_r;
    age_nxt    = age_r;
    count_nxt  = count_r;
    if (fire) begin
      if (hit) begin
        // touch: entries more recent than the hit age by one
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i] && (age_r[i] < found_age)) begin
            age_nxt[i] = age_r[i] + AGE_W'(1);
          end
        end
        age_nxt[found_idx] = '0;
        if (req.cmd == CMD_PUT) begin
          values_nxt[found_idx] = req.value;
        end
      end else if (req.cmd == CMD_PUT && cap != '0) begin
        if (count_r >= cap) begin
          // full: reuse the least recent slot
          if (victim_ok) begin
            for (int i = 0; i < ENTRIES; i++) begin
              if (valid_r[i]) begin
                age_nxt[i] = age_r[i] + AGE_W'(1);
              end
            end
            keys_nxt[victim_idx]   = req.key;
            values_nxt[victim_idx] = req.value;
            age_nxt[victim_idx]    = '0;
          end
        end else begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_r[i]) begin
              age_nxt[i] = age_r[i] + AGE_W'(1);
            end
          end
          valid_nxt[free_idx]  = 1'b1;
          keys_nxt[free_idx]   = req.key;
          values_nxt[free_idx] = req.value;
          age_nxt[free_idx]    = '0;
          count_nxt            = count_r + CNT_W'(1);
        end
      end
    end
  end

  // key/value arrays carry no reset
  always_ff @(posedge clk) begin
    keys_r   <= keys_nxt;
    values_r <= values_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      count_r    <= '0;
      capacity_r <= CAP_W'(CAP_RESET);
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else if (cfg_we) begin
      valid_r    <= '0;
      count_r    <= '0;
      capacity_r <= cfg_data;
      for (int i = 0; i < ENTRIES; i++) begin
        age_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      age_r   <= age_nxt;
    end
  end

  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(count_r))
    else $error("entry count disagrees with valid marks");

  a_count_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap)
    else $error("entry count above capacity");

  a_keys_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("key present in more than one entry");

  a_hit_becomes_mru: assert property (@(posedge clk) disable iff (!rst_n)
    fire && hit && !cfg_we |=> age_r[$past(found_idx)] == '0)
    else $error("hit entry not most recent afterwards");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (valid_r == '0) && (count_r == '0))
    else $error("capacity write did not clear the store");

endmodule

// ===== rtl/lru_key_value_cache_unit.sv =====
// LRU key-value cache top level: input register, store, output register.
// Throughput: one word per cycle unless out_stall holds the output register; the store
// is read and updated combinationally between the input and output registers, so
// back-to-back items see each other's updates. Reset (rst_n low, synchronous) clears
// valid marks, ages and count, sets capacity to 16; no clearing pass. A capacity
// write also clears.
module lru_key_value_cache_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic signed [lkv_pkg::DATA_W-1:0] in_key,
  input  logic signed [lkv_pkg::DATA_W-1:0] in_value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  output logic signed [lkv_pkg::DATA_W-1:0] out_read_value,
  // capacity register write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0]         cfg_capacity
);
  import lkv_pkg::*;

  logic in_valid_r;
  req_t req_r;
  logic out_valid_r;
  rsp_t rsp_r;
  rsp_t rsp;
  logic fire;
  logic cfg_we;

  // compute fires when an item is held and the output slot is free or draining
  assign fire     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !fire;

  // the user must issue capacity writes only while idle; the block does not check, so always takes them
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  // input word register (payload, no reset)
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r.cmd   <= cmd_t'(in_cmd);
      req_r.key   <= in_key;
      req_r.value <= in_value;
    end
  end

  lkv_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .req      (req_r),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_capacity)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result word register (payload, no reset)
  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_r <= rsp;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = rsp_r.hit;
  assign out_read_value = rsp_r.read_value;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked output");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("computed item did not reach the output register");

  a_held_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(rsp_r))
    else $error("stalled result changed");

endmodule

// ===== tb/lru_cache_checker.sv =====
// Scoreboard for the LRU key-value cache: watches the request, result and capacity channels.
// Keeps its own LRU store to predict every result. Depends on lkv_pkg.
`timescale 1ns / 100ps

module lru_cache_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              in_cmd,
  input  logic signed [lkv_pkg::DATA_W-1:0] in_key,
  input  logic signed [lkv_pkg::DATA_W-1:0] in_value,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic                              out_hit,
  input  logic signed [lkv_pkg::DATA_W-1:0] out_read_value,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0]         cfg_capacity,
  output int                                fail_count,
  output int                                outstanding
);
  import lkv_pkg::*;

  localparam int REPORT_MAX = 100;

  logic [DATA_W-1:0] slot_key [ENTRIES];
  logic [DATA_W-1:0] slot_val [ENTRIES];
  bit                slot_used [ENTRIES];
  int unsigned       slot_rank [ENTRIES];  // 0 = most recent
  int unsigned       used_slots;
  int unsigned       cap_setting;
  rsp_t              answer_q [$];
  int                errors = 0;

  function automatic void clear_slots();
    for (int i = 0; i < ENTRIES; i++) begin
      slot_used[i] = 1'b0;
      slot_rank[i] = 0;
    end
    used_slots = 0;
  endfunction

  // Move one entry to the front; the ones that were ahead of it age by one.
  function automatic void make_recent(int idx);
    int unsigned old_rank;
    old_rank = slot_rank[idx];
    for (int i = 0; i < ENTRIES; i++)
      if (slot_used[i] && slot_rank[i] < old_rank) slot_rank[i]++;
    slot_rank[idx] = 0;
  endfunction

  function automatic rsp_t lru_lookup_update(cmd_t cmd, logic [DATA_W-1:0] key,
                                             logic [DATA_W-1:0] value);
    rsp_t        answer;
    int          found;
    int          victim;
    int unsigned limit;
    found = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (found < 0 && slot_used[i] && slot_key[i] == key) found = i;
    answer.hit = (found >= 0);

    if (cmd == CMD_GET) begin
      answer.read_value = (found >= 0) ? slot_val[found] : MISS_VALUE;
      if (found >= 0) make_recent(found);
      return answer;
    end

    answer.read_value = PUT_VALUE;
    limit = (cap_setting > ENTRIES) ? ENTRIES : cap_setting;
    if (found >= 0) begin
      slot_val[found] = value;
      make_recent(found);
    end else if (limit != 0) begin
      victim = -1;
      if (used_slots >= limit) begin
        // full: reuse the oldest slot, everyone else ages
        for (int i = 0; i < ENTRIES; i++)
          if (slot_used[i] && slot_rank[i] == used_slots - 1) victim = i;
        if (victim >= 0) begin
          for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && i != victim) slot_rank[i]++;
          slot_key[victim]  = key;
          slot_val[victim]  = value;
          slot_rank[victim] = 0;
        end
      end else begin
        for (int i = 0; i < ENTRIES; i++)
          if (victim < 0 && !slot_used[i]) victim = i;
        if (victim >= 0) begin
          for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i]) slot_rank[i]++;
          slot_used[victim] = 1'b1;
          slot_key[victim]  = key;
          slot_val[victim]  = value;
          slot_rank[victim] = 0;
          used_slots++;
        end
      end
    end
    return answer;
  endfunction

  // Results are checked before new requests are queued so a stray result
  // can never be matched against a word accepted at the same edge.
  always @(posedge clk) begin : watch
    rsp_t want;
    if (!rst_n) begin
      cap_setting = CAP_RESET;
      clear_slots();
      answer_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("%0t: unexpected result word, expected none, got hit=%0b value=%0d",
                     $time, out_hit, out_read_value);
        end else begin
          want = answer_q.pop_front();
          if (want.hit !== out_hit) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("%0t: hit mismatch, expected %0b, got %0b", $time, want.hit, out_hit);
          end
          if (want.read_value !== out_read_value) begin
            errors++;
            if (errors <= REPORT_MAX)
              $display("%0t: read_value mismatch, expected %0d, got %0d",
                       $time, want.read_value, out_read_value);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        cap_setting = 32'(cfg_capacity);
        clear_slots();
      end
      if (in_valid && !in_stall)
        answer_q.push_back(lru_lookup_update(cmd_t'(in_cmd), in_key, in_value));
    end
    fail_count  <= errors;
    outstanding <= answer_q.size();
  end

endmodule

// ===== tb/lru_key_value_cache_unit_tb.sv =====
// Top of the LRU key-value cache testbench: clock, reset, stimulus and verdict.
// Instantiates lru_key_value_cache_unit and lru_cache_checker; depends on lkv_pkg.
`timescale 1ns / 100ps

module lru_key_value_cache_unit_tb;
  import lkv_pkg::*;

  logic                     clk;
  logic                     rst_n = 1'b0;

  // request side: all inputs start at known values
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_cmd = CMD_GET;
  logic signed [DATA_W-1:0] in_key = '0;
  logic signed [DATA_W-1:0] in_value = '0;

  // result side
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_hit;
  logic signed [DATA_W-1:0] out_read_value;

  // capacity register
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CAP_W-1:0]         cfg_capacity = '0;

  int                       fail_count;
  int                       outstanding;

  // When set, neither side idles: back-to-back words in both directions.
  bit                       calm = 1'b0;
  int unsigned              words_sent = 0;
  int unsigned              cap_writes = 0;

  lru_key_value_cache_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_capacity   (cfg_capacity)
  );

  lru_cache_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_capacity   (cfg_capacity),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. Slowest legal run is about 1100 words, each with its longest gap and stall,
  // plus the drains; this allows several times that.
  initial begin
    #2_000_000;
    $display("Timed out with %0d result words still outstanding", outstanding);
    $display("Some tests failed");
    $finish;
  end

  // Result sink: before taking each word it may raise stall, except in calm stretches.
  // Every read of a DUT output happens right after the edge, so it sees the
  // value that the edge itself sampled.
  initial begin : result_sink
    int unsigned hold;
    do @(posedge clk); while (!rst_n);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 8);
      out_stall <= (hold != 0);
      repeat (hold) @(posedge clk);
      if (hold != 0) out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // One request word. Called in the time step right after an edge, so that
  // lowering in_valid for a gap never collides with raising it again.
  task automatic send_word(cmd_t cmd, logic [DATA_W-1:0] key, logic [DATA_W-1:0] value);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_key   <= key;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Stop sending and let every pending result drain, then wait out the
  // pipeline registers. outstanding is updated at the edge, so it lags the
  // checker's own queue.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // Capacity writes only land on an idle block; each one also empties the store.
  task automatic set_capacity(logic [CAP_W-1:0] cap);
    settle();
    cfg_valid    <= 1'b1;
    cfg_capacity <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_writes++;
  endtask

  // Mostly keys from a small per-phase pool so that hits, overwrites and
  // evictions are common; the rest are fresh random keys and the corner keys.
  task automatic random_phase(int unsigned n_words);
    logic [DATA_W-1:0] key_pool [24];
    logic [DATA_W-1:0] key;
    int unsigned       pool_n;
    int unsigned       pick;
    cmd_t              cmd;
    pool_n = $urandom_range(2, 24);
    for (int i = 0; i < 24; i++) key_pool[i] = $urandom;
    repeat (n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        key = key_pool[$urandom_range(0, pool_n - 1)];
      end else if (pick < 93) begin
        key = $urandom;
      end else begin
        case ($urandom_range(0, 3))
          0: key = 32'h7FFF_FFFF;
          1: key = 32'h8000_0000;
          2: key = 32'h0000_0000;
          default: key = 32'hFFFF_FFFF;
        endcase
      end
      cmd = ($urandom_range(0, 1) != 0) ? CMD_PUT : CMD_GET;
      send_word(cmd, key, $urandom);
      // occasional full drain in the middle of a phase
      if ($urandom_range(0, 63) == 0) settle();
    end
  endtask

  initial begin : stimulus
    logic [CAP_W-1:0] cap;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset capacity (16): empty-store miss, extreme keys and
    // values, overwrite of a present key, get ignores its value field.
    send_word(CMD_GET, 32'h0000_0000, $urandom);
    send_word(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(CMD_GET, 32'h7FFF_FFFF, $urandom);
    send_word(CMD_GET, 32'h8000_0000, $urandom);
    send_word(CMD_GET, 32'h0000_0000, $urandom);
    send_word(CMD_GET, 32'hFFFF_FFFF, $urandom);
    send_word(CMD_GET, 32'h0000_0001, $urandom);
    send_word(CMD_PUT, 32'h0000_0000, 32'd5);
    send_word(CMD_GET, 32'h0000_0000, $urandom);

    // Capacity 2: a get refreshes key 10, so the next new key evicts key 20.
    set_capacity(5'd2);
    send_word(CMD_PUT, 32'd10, 32'd100);
    send_word(CMD_PUT, 32'd20, 32'd200);
    send_word(CMD_GET, 32'd10, $urandom);
    send_word(CMD_PUT, 32'd30, 32'd300);
    send_word(CMD_GET, 32'd20, $urandom);
    send_word(CMD_GET, 32'd10, $urandom);
    send_word(CMD_GET, 32'd30, $urandom);

    // Capacity 0: puts store nothing, so a repeated put still misses.
    set_capacity(5'd0);
    send_word(CMD_PUT, 32'd7, 32'd70);
    send_word(CMD_GET, 32'd7, $urandom);
    send_word(CMD_PUT, 32'd7, 32'd71);

    // Capacity 1: the store holds a single key.
    set_capacity(5'd1);
    send_word(CMD_PUT, 32'd1, 32'd1);
    send_word(CMD_PUT, 32'd2, 32'd2);
    send_word(CMD_GET, 32'd1, $urandom);

    // Random phases, each under its own capacity: above the entry count
    // (saturates at 16), exactly 16, tiny, zero, mid-range and random values.
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: cap = 5'd31;
        1: cap = 5'd16;
        2: cap = 5'd1;
        3: cap = 5'd0;
        4: cap = 5'd17;
        5: cap = 5'd2;
        6: cap = 5'd15;
        7: cap = 5'd8;
        default: cap = CAP_W'($urandom_range(0, 31));
      endcase
      set_capacity(cap);
      calm = (phase % 4 == 2);
      random_phase(108);
    end
    calm = 1'b0;

    settle();
    $display("Covered %0d request words over %0d capacity settings (reset value included),",
             words_sent, cap_writes + 1);
    $display("with random gaps and stalls on both channels and idle-free stretches");
    if (outstanding != 0)
      $display("%0d expected result words never arrived", outstanding);
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
